@@ src/bes_pkg.sv @@
package bes_pkg;

    // Expression characters
    localparam logic [7:0] CH_TRUE  = 8'h74;  // t
    localparam logic [7:0] CH_FALSE = 8'h66;  // f
    localparam logic [7:0] CH_AND   = 8'h26;  // &
    localparam logic [7:0] CH_OR    = 8'h7C;  // |
    localparam logic [7:0] CH_NOT   = 8'h21;  // !
    localparam logic [7:0] CH_CLOSE = 8'h29;  // )

    // Frame operators
    localparam logic [1:0] OP_AND = 2'd1;
    localparam logic [1:0] OP_OR  = 2'd2;
    localparam logic [1:0] OP_NOT = 2'd3;

    // Command kinds after decode
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_LIT  = 2'd1;
    localparam logic [1:0] K_PUSH = 2'd2;
    localparam logic [1:0] K_POP  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       val;
    } t_frame;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       value;
        logic       error;
    } t_result;

    typedef struct packed {
        logic [1:0] kind;
        t_frame     frame;  // operator and start value of a push, literal in val
    } t_dec;

    function automatic t_dec decode(input logic [7:0] ch);
        t_dec d;
        d.kind      = K_NONE;
        d.frame.op  = OP_AND;
        d.frame.val = 1'b0;
        unique case (ch)
            CH_TRUE: begin
                d.kind      = K_LIT;
                d.frame.val = 1'b1;
            end
            CH_FALSE: d.kind = K_LIT;
            CH_AND: begin
                d.kind      = K_PUSH;
                d.frame.op  = OP_AND;
                d.frame.val = 1'b1;
            end
            CH_OR: begin
                d.kind     = K_PUSH;
                d.frame.op = OP_OR;
            end
            CH_NOT: begin
                d.kind     = K_PUSH;
                d.frame.op = OP_NOT;
            end
            CH_CLOSE: d.kind = K_POP;
            default: d.kind = K_NONE;
        endcase
        return d;
    endfunction

    // Combine an operand into a frame's running value
    function automatic logic fold(input logic [1:0] op, input logic acc, input logic v);
        logic r;
        case (op)
            OP_OR:   r = acc | v;
            OP_NOT:  r = ~v;
            default: r = acc & v;
        endcase
        return r;
    endfunction

endpackage

@@ src/bes_frame_stack.sv @@
module bes_frame_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bes_pkg::t_cmd      i_cmd,
    output bes_pkg::t_result   o_result
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    // Frames below the parent live in memory; top and parent are cached,
    // and the frame under the parent is prefetched into r_pre.
    bes_pkg::t_frame mem [STACK_DEPTH];

    logic [DW-1:0]   r_depth, n_depth;
    logic            r_top_value, n_top_value;
    logic            r_have_top, n_have_top;
    logic            r_err, n_err;
    bes_pkg::t_frame r_top, n_top;
    bes_pkg::t_frame r_par, n_par;
    bes_pkg::t_frame r_pre;

    bes_pkg::t_dec   dec;
    logic            do_push;
    logic            do_pop;
    logic [DW-1:0]   wr_idx;
    logic [DW-1:0]   rd_idx;

    assign dec    = bes_pkg::decode(i_cmd.ch);
    assign wr_idx = r_depth - DW'(2);
    assign rd_idx = r_depth - DW'(4);

    // Next state for one character
    always_comb begin
        n_depth     = r_depth;
        n_top_value = r_top_value;
        n_have_top  = r_have_top;
        n_err       = r_err;
        n_top       = r_top;
        n_par       = r_par;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        case (dec.kind)
            bes_pkg::K_LIT: begin
                if (r_depth == '0) begin
                    n_top_value = dec.frame.val;
                    n_have_top  = 1'b1;
                end else begin
                    n_top.val = bes_pkg::fold(r_top.op, r_top.val, dec.frame.val);
                end
            end
            bes_pkg::K_PUSH: begin
                if (r_depth == FULL) begin
                    n_err = 1'b1;
                end else begin
                    do_push = 1'b1;
                    n_top   = dec.frame;
                    n_par   = r_top;
                    n_depth = r_depth + DW'(1);
                end
            end
            bes_pkg::K_POP: begin
                if (r_depth == '0) begin
                    n_err = 1'b1;
                end else if (r_depth == DW'(1)) begin
                    n_top_value = r_top.val;
                    n_have_top  = 1'b1;
                    n_depth     = '0;
                end else begin
                    do_pop    = 1'b1;
                    n_top.op  = r_par.op;
                    n_top.val = bes_pkg::fold(r_par.op, r_par.val, r_top.val);
                    n_par     = r_pre;
                    n_depth   = r_depth - DW'(1);
                end
            end
            default: ;
        endcase
    end

    // Result as seen after this character
    always_comb begin
        o_result.error = n_err | (n_depth != '0) | ~n_have_top;
        o_result.value = n_top_value & ~o_result.error;
    end

    // Control state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_top_value <= 1'b0;
            r_have_top  <= 1'b0;
            r_err       <= 1'b0;
        end else if (i_cmd.valid) begin
            if (i_cmd.last) begin
                r_depth     <= '0;
                r_top_value <= 1'b0;
                r_have_top  <= 1'b0;
                r_err       <= 1'b0;
            end else begin
                r_depth     <= n_depth;
                r_top_value <= n_top_value;
                r_have_top  <= n_have_top;
                r_err       <= n_err;
            end
        end
    end

    // Cached frames
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_top <= n_top;
            r_par <= n_par;
        end
    end

    // Spill parent on push, refill prefetch on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && do_push && (r_depth >= DW'(2))) begin
            mem[wr_idx[AW-1:0]] <= r_par;
        end
        if (i_cmd.valid && do_push) begin
            r_pre <= r_par;
        end else if (i_cmd.valid && do_pop) begin
            r_pre <= mem[rd_idx[AW-1:0]];
        end
    end

endmodule

@@ src/bool_expr_stream_evaluator.sv @@
// Prefix boolean expression evaluator. Send one character per request on the
// slave stream (t, f, &, |, !, ')' matter; '(' ',' and all other bytes are
// skipped) and mark the final character with tlast. After the final character
// one result appears on the master stream: tdata bit 0 is the value and tuser
// is the error flag (stack overflow, unmatched ')', unclosed operator or no
// value); the value reads 0 when the error flag is set. Every character
// passes an input register and updates the operator stack, whose top two
// frames sit in registers and the rest in a single-port memory of
// STACK_DEPTH entries, and the result is held in an output register. A
// character is taken every cycle; only a final character waits while an
// earlier result is still held on the master side.
module bool_expr_stream_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [0] value, [7:1] zero
    output logic       o_m_axis_tuser    // [0] error
);

    logic              r_in_valid;
    logic [7:0]        r_in_ch;
    logic              r_in_last;
    logic              r_out_valid;
    bes_pkg::t_result  r_out;
    bes_pkg::t_result  result;
    bes_pkg::t_cmd     cmd;
    logic              advance;

    // A final character needs a free result slot
    assign advance = r_in_valid & (~r_in_last | ~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | advance;

    assign cmd.valid = advance;
    assign cmd.ch    = r_in_ch;
    assign cmd.last  = r_in_last;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    bes_frame_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.value};
    assign o_m_axis_tuser  = r_out.error;

endmodule

@@ src/bes_checker.sv @@
module bes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser
);

    // Hold a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Drop the value of a failed expression
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[0] == 1'b0)
        else $error("value set with error flag");

    // Keep pad bits clear
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:1] == 7'd0)
        else $error("pad bits set");

    // No result straight out of reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A free result side never stalls the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && $past(!o_m_axis_tvalid) && $past(i_rst_n) |-> o_s_axis_tready)
        else $error("input stalled while output idle");

endmodule

bind bool_expr_stream_evaluator bes_checker u_bes_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
